FILE: design/tlfs_pkg.sv
package tlfs_pkg;

  localparam int MaxProcs = 16;
  localparam int SlotW = $clog2(MaxProcs);
  localparam int CntW = SlotW + 1;
  localparam logic [7:0] QuantumReset = 8'd4;
  localparam logic [1:0] AddrQuantum = 2'd0;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic  start_arrive;
    logic  start_tick;
    logic  shift_step;
    slot_t shift_idx;
    logic  finish;
  } tlfs_cmd_t;

  typedef struct packed {
    logic  full;
    logic  walk_done;
    cnt_t  ins_pos;
    cnt_t  prio_count;
  } tlfs_stat_t;

  typedef struct packed {
    logic accepted;
    logic running_valid;
    logic [7:0] running_pid;
    logic running_from_rr;
    logic finished;
  } tlfs_res_t;

endpackage

FILE: design/two_level_feedback_scheduler_top.sv
// Two-level scheduler: arrive beats (tdata command=0) insert a job into a
// priority-sorted queue, or are rejected when every slot is used; tick
// beats (command=1) run one scheduling step and report which job ran. Every
// input beat gives one output beat. A tick needs no busy states; an accepted
// arrival holds off the next accept through the sequential walk to the insertion
// point and the shift of the entries behind it. Time quantum at address 0.
module two_level_feedback_scheduler_top
  import tlfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // command, proc_id, burst_len, prio
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // accepted, running_valid, running_pid, running_from_rr, finished
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] time_quantum;
  tlfs_cmd_t  cmd;
  tlfs_stat_t stat;
  tlfs_res_t  res;
  logic       res_load;
  logic       res_free;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrQuantum) ? {24'd0, time_quantum} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_quantum <= QuantumReset;
    end else if (psel && penable && pwrite && paddr == AddrQuantum) begin
      time_quantum <= pwdata[7:0];
    end
  end

  assign res_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {4'd0, res.finished, res.running_from_rr, res.running_pid,
                  res.running_valid, res.accepted};
    end
  end

  tlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tdata[0]),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .res_load (res_load),
    .res_free (res_free)
  );

  tlfs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .proc_id      (s_tdata[8:1]),
    .burst_len    (s_tdata[24:9]),
    .prio         (s_tdata[28:25]),
    .time_quantum (time_quantum),
    .res          (res)
  );

endmodule

FILE: design/tlfs_ctrl.sv
module tlfs_ctrl
  import tlfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  tlfs_stat_t stat,
  output tlfs_cmd_t  cmd,
  output logic       res_load,
  input  logic       res_free
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t state;
  cnt_t   idx;

  assign in_ready = (state == S_IDLE) && res_free;

  always_comb begin
    cmd = '0;
    cmd.start_arrive = in_ready && in_valid && (in_cmd == CMD_ARRIVE);
    cmd.start_tick   = in_ready && in_valid && (in_cmd == CMD_TICK);
    cmd.shift_step   = (state == S_SHIFT);
    cmd.shift_idx    = idx[SlotW-1:0];
    cmd.finish       = (state == S_DONE);
  end

  assign res_load = (state == S_DONE) || cmd.start_tick ||
                    (cmd.start_arrive && stat.full);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start_arrive && !stat.full) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (stat.walk_done) begin
            idx   <= stat.prio_count;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (idx == stat.ins_pos) begin
            state <= S_DONE;
          end else begin
            idx <= idx - cnt_t'(1);
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> state == S_IDLE)
    else $error("done not single cycle");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready)
    else $error("ready while busy");
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> idx >= stat.ins_pos)
    else $error("shift index under position");
`endif

endmodule

FILE: design/tlfs_dp.sv
module tlfs_dp
  import tlfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tlfs_cmd_t   cmd,
  output tlfs_stat_t  stat,
  input  logic [7:0]  proc_id,
  input  logic [15:0] burst_len,
  input  logic [3:0]  prio,
  input  logic [7:0]  time_quantum,
  output tlfs_res_t   res
);

  logic [7:0]       slot_pid [MaxProcs];
  logic [15:0]      slot_rem [MaxProcs];
  logic [3:0]       slot_prio [MaxProcs];
  logic [MaxProcs-1:0] slot_used;
  slot_t            prio_order [MaxProcs];
  cnt_t             prio_count;
  slot_t            rr_ring [MaxProcs];
  slot_t            rr_head;
  cnt_t             rr_count;
  slot_t            cur_slot;
  logic             cpu_busy;
  logic             cur_level_rr;
  logic [7:0]       quantum_left;

  slot_t      new_slot;
  logic [3:0] new_prio;
  cnt_t       walk;
  logic       free_found;
  slot_t      free_slot;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = MaxProcs - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_slot  = slot_t'(i);
      end
    end
  end

  logic walk_stop;
  assign walk_stop = (walk >= prio_count) ||
                     (slot_prio[prio_order[walk[SlotW-1:0]]] > new_prio);

  always_comb begin
    stat = '0;
    stat.full       = !free_found;
    stat.walk_done  = walk_stop;
    stat.ins_pos    = walk;
    stat.prio_count = prio_count;
  end

  // tick decision, combinational on current state
  logic  t_busy, t_rr, t_take_pq, t_take_rr, t_push_cur;
  slot_t t_cur;
  logic [7:0] t_q;

  always_comb begin
    t_busy = cpu_busy;
    t_rr   = cur_level_rr;
    t_cur  = cur_slot;
    t_q    = quantum_left;
    t_take_pq  = 1'b0;
    t_take_rr  = 1'b0;
    t_push_cur = 1'b0;
    if (!cpu_busy) begin
      if (prio_count != '0) begin
        t_take_pq = 1'b1;
      end else if (rr_count != '0) begin
        t_take_rr = 1'b1;
      end
    end else if (prio_count != '0) begin
      if (!cur_level_rr) begin
        if (slot_prio[prio_order[0]] < slot_prio[cur_slot]) begin
          t_push_cur = 1'b1;
          t_take_pq  = 1'b1;
        end
      end else begin
        t_push_cur = 1'b1;
        t_take_pq  = 1'b1;
      end
    end
    if (t_take_pq) begin
      t_busy = 1'b1;
      t_rr   = 1'b0;
      t_cur  = prio_order[0];
      t_q    = time_quantum;
    end else if (t_take_rr) begin
      t_busy = 1'b1;
      t_rr   = 1'b1;
      t_cur  = rr_ring[rr_head];
      t_q    = time_quantum;
    end
    if (t_busy && t_rr && t_q != 8'd0) begin
      t_q = t_q - 8'd1;
    end
  end

  logic t_fin, t_expire;
  assign t_fin    = t_busy && (slot_rem[t_cur] <= 16'd1);
  assign t_expire = t_busy && !t_fin && t_rr && (t_q == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used    <= '0;
      prio_count   <= '0;
      rr_head      <= '0;
      rr_count     <= '0;
      cur_slot     <= '0;
      cpu_busy     <= 1'b0;
      cur_level_rr <= 1'b0;
      quantum_left <= QuantumReset;
      walk         <= '0;
    end else begin
      if (cmd.start_arrive && free_found) begin
        slot_used[free_slot] <= 1'b1;
        slot_pid[free_slot]  <= proc_id;
        slot_rem[free_slot]  <= burst_len;
        slot_prio[free_slot] <= prio;
        new_slot <= free_slot;
        new_prio <= prio;
        walk     <= '0;
      end else if (!walk_stop) begin
        walk <= walk + cnt_t'(1);
      end
      if (cmd.shift_step) begin
        if (cnt_t'(cmd.shift_idx) == walk) begin
          prio_order[cmd.shift_idx] <= new_slot;
        end else begin
          prio_order[cmd.shift_idx] <= prio_order[cmd.shift_idx - slot_t'(1)];
        end
      end
      if (cmd.finish) begin
        prio_count <= prio_count + cnt_t'(1);
      end
      if (cmd.start_tick) begin
        if (t_take_pq) begin
          for (int i = 1; i < MaxProcs; i++) begin
            prio_order[i-1] <= prio_order[i];
          end
          prio_count <= prio_count - cnt_t'(1);
        end
        if (t_take_rr) begin
          rr_head <= rr_head + slot_t'(1);
          if (t_expire) begin
            rr_ring[rr_head + rr_count[SlotW-1:0]] <= t_cur;
          end else begin
            rr_count <= rr_count - cnt_t'(1);
          end
        end else if (t_push_cur) begin
          rr_ring[rr_head + rr_count[SlotW-1:0]] <= cur_slot;
          rr_count <= rr_count + cnt_t'(1);
        end else if (t_expire) begin
          rr_ring[rr_head + rr_count[SlotW-1:0]] <= t_cur;
          rr_count <= rr_count + cnt_t'(1);
        end
        cur_slot <= t_cur;
        if (t_fin) begin
          slot_rem[t_cur]  <= '0;
          slot_used[t_cur] <= 1'b0;
          cpu_busy     <= 1'b0;
          cur_level_rr <= 1'b0;
          quantum_left <= time_quantum;
        end else begin
          if (t_busy) begin
            slot_rem[t_cur] <= slot_rem[t_cur] - 16'd1;
          end
          cpu_busy     <= t_busy && !t_expire;
          cur_level_rr <= t_rr && !t_expire;
          quantum_left <= t_q;
        end
      end
    end
  end

  always_comb begin
    res = '0;
    res.accepted = !(cmd.start_arrive && !free_found);
    if (cmd.start_tick && t_busy) begin
      res.running_valid   = 1'b1;
      res.running_pid     = slot_pid[t_cur];
      res.running_from_rr = t_rr;
      res.finished        = t_fin;
    end
  end

`ifndef SYNTHESIS
  a_rr_bound: assert property (@(posedge clk) disable iff (rst)
    rr_count <= cnt_t'(MaxProcs))
    else $error("rr overflow");
  a_pq_bound: assert property (@(posedge clk) disable iff (rst)
    prio_count <= cnt_t'(MaxProcs))
    else $error("pq overflow");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start_tick && t_fin |=> !cpu_busy)
    else $error("busy after finish");
`endif

endmodule

FILE: dv/two_level_feedback_scheduler_top_tb.sv
module two_level_feedback_scheduler_top_tb;
  import tlfs_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;  // command, proc_id, burst_len, prio
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;  // accepted, running_valid, running_pid, running_from_rr, finished
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  localparam int CycleLimit = 3000000;

  two_level_feedback_scheduler_top u_top (.*);

  // scheduler state mirror
  logic [7:0]  job_pid[MaxProcs];
  logic [15:0] job_left[MaxProcs];
  logic [3:0]  job_prio[MaxProcs];
  bit          job_used[MaxProcs];
  int          prio_queue[$];
  int          rr_queue[$];
  int          cur_job;
  bit          cpu_busy;
  bit          on_rr;
  logic [7:0]  quantum_left;
  logic [7:0]  quantum;

  tlfs_res_t   pending_results[$];
  int          mismatches;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  function automatic tlfs_res_t schedule_step(cmd_t cmd, logic [7:0] pid,
                                              logic [15:0] burst, logic [3:0] prio);
    tlfs_res_t r;
    int s;
    int pos;
    r = '0;
    r.accepted = 1'b1;
    if (cmd == CMD_ARRIVE) begin
      s = 0;
      while (s < MaxProcs && job_used[s]) s++;
      if (s >= MaxProcs) begin
        r.accepted = 1'b0;
        return r;
      end
      job_used[s] = 1;
      job_pid[s] = pid;
      job_left[s] = burst;
      job_prio[s] = prio;
      pos = 0;
      while (pos < prio_queue.size() && job_prio[prio_queue[pos]] <= prio) pos++;
      prio_queue.insert(pos, s);
      return r;
    end
    if (!cpu_busy) begin
      if (prio_queue.size() > 0) begin
        cur_job = prio_queue.pop_front();
        cpu_busy = 1;
        on_rr = 0;
        quantum_left = quantum;
      end else if (rr_queue.size() > 0) begin
        cur_job = rr_queue.pop_front();
        cpu_busy = 1;
        on_rr = 1;
        quantum_left = quantum;
      end
    end else if (prio_queue.size() > 0) begin
      if (on_rr || job_prio[prio_queue[0]] < job_prio[cur_job]) begin
        rr_queue.push_back(cur_job);
        cur_job = prio_queue.pop_front();
        on_rr = 0;
        quantum_left = quantum;
      end
    end
    if (cpu_busy) begin
      r.running_valid = 1'b1;
      r.running_pid = job_pid[cur_job];
      r.running_from_rr = on_rr;
      if (on_rr && quantum_left > 0) quantum_left--;
      if (job_left[cur_job] <= 1) begin
        job_left[cur_job] = 0;
        job_used[cur_job] = 0;
        r.finished = 1'b1;
        cpu_busy = 0;
        on_rr = 0;
        quantum_left = quantum;
      end else begin
        job_left[cur_job]--;
        if (on_rr && quantum_left == 0) begin
          rr_queue.push_back(cur_job);
          cpu_busy = 0;
          on_rr = 0;
        end
      end
    end
    return r;
  endfunction

  function automatic int jobs_held();
    int n;
    n = 0;
    for (int i = 0; i < MaxProcs; i++) n += job_used[i];
    return n;
  endfunction

  task automatic send_item(cmd_t cmd, logic [7:0] pid, logic [15:0] burst,
                           logic [3:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, prio, burst, pid, cmd};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(schedule_step(cmd, pid, burst, prio));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic write_quantum(logic [7:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrQuantum;
    pwdata <= {24'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    quantum = value;
  endtask

  task automatic tick();
    send_item(CMD_TICK, 8'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic test_preemption();
    send_item(CMD_ARRIVE, 8'd255, 16'd3, 4'd15);
    tick();
    send_item(CMD_ARRIVE, 8'd0, 16'd2, 4'd0);
    repeat (2) tick();
    send_item(CMD_ARRIVE, 8'd7, 16'd0, 4'd8);
    send_item(CMD_ARRIVE, 8'd8, 16'd65535, 4'd15);
    repeat (4) tick();
    send_item(CMD_ARRIVE, 8'd9, 16'd1, 4'd3);
    send_item(CMD_ARRIVE, 8'd10, 16'd1, 4'd3);
    repeat (6) tick();
  endtask

  task automatic test_table_full();
    int guard;
    while (jobs_held() < MaxProcs)
      send_item(CMD_ARRIVE, 8'($urandom), 16'($urandom_range(1, 3)), 4'($urandom));
    send_item(CMD_ARRIVE, 8'hA5, 16'd5, 4'd1);
    guard = 0;
    while (jobs_held() > 1 && guard < 200) begin
      tick();
      guard++;
    end
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct, logic [7:0] q);
    int pick;
    logic [15:0] burst;
    write_quantum(q);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      if ($urandom_range(99) < 45) begin
        pick = $urandom_range(99);
        if (pick < 8) burst = 16'd0;
        else if (pick < 10) burst = 16'($urandom);
        else burst = 16'($urandom_range(1, 8));
        send_item(CMD_ARRIVE, 8'($urandom), burst, 4'($urandom));
      end else begin
        tick();
      end
    end
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    tlfs_res_t got;
    tlfs_res_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("two_level_feedback_scheduler_top test failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = tlfs_res_t'({m_tdata[0], m_tdata[1], m_tdata[9:2], m_tdata[10], m_tdata[11]});
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < MaxProcs; i++) job_used[i] = 0;
    cpu_busy = 0;
    on_rr = 0;
    cur_job = 0;
    quantum = QuantumReset;
    quantum_left = QuantumReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_preemption();
    test_table_full();
    test_random(360, 0, 0, 8'd1);
    test_random(360, 78, 0, 8'd255);
    test_random(360, 0, 78, 8'd0);
    test_random(360, 20, 20, 8'($urandom_range(2, 6)));
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("two_level_feedback_scheduler_top test passed");
    else
      $display("two_level_feedback_scheduler_top test failed");
    $finish;
  end

endmodule
